// File: hdl/query_slot_bitmap_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot bitmap allocator
// Clocked, reset-qualified property checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef QUERY_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define QUERY_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// Check a whole property on every clock edge outside reset
`define QSBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define QSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/qsba_pkg.sv
// ----------------------------------------------------------------------------
// qsba_pkg
// Shared constants, types and helper functions of the slot bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package qsba_pkg;

	// Capacity and derived sizes
	localparam int SLOT_COUNT = 256;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;
	localparam int WPTR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int HINT_W     = $clog2(SLOT_COUNT + 1);
	localparam int ROW_W      = 2 * WORD_BITS;

	// Stream field widths
	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 8;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 16;

	localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_MARK    = 2'd2,
		CMD_CHECK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_CHK_FETCH,
		ST_CHK,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic inc_ptr;
		logic load_hw;
		logic check;
		logic push;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic skip;
		logic acquire;
		logic release_op;
		logic word_full;
		logic ptr_last;
		logic need_chk;
	} dp_status_t;

	// Position of the lowest clear bit of a word
	function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] n;
		n = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) n = BIT_W'(i);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hdl/qsba_ctrl.sv
// ----------------------------------------------------------------------------
// qsba_ctrl
// Sequencer for the allocator: fetch, execute, hint check and result push.
// ----------------------------------------------------------------------------
`default_nettype none

module qsba_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire qsba_pkg::dp_status_t status,
	output qsba_pkg::ctrl_cmd_t       cmd
);
	import qsba_pkg::*;

	state_t state_q, state_nxt;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_FETCH;
			end
			ST_FETCH: begin
				state_nxt = status.skip ? ST_DONE : ST_EXEC;
			end
			ST_EXEC: begin
				if (status.acquire && status.word_full && !status.ptr_last) begin
					state_nxt = ST_FETCH;
				end else if (status.release_op && status.need_chk) begin
					state_nxt = ST_CHK_FETCH;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_CHK_FETCH: state_nxt = ST_CHK;
			ST_CHK:       state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		s_tready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_EXEC: begin
				cmd.exec    = 1'b1;
				cmd.inc_ptr = status.acquire && status.word_full && !status.ptr_last;
				cmd.load_hw = status.release_op && status.need_chk;
			end
			ST_CHK: cmd.check = 1'b1;
			ST_DONE: cmd.push = out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Result valid: set on push, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: hdl/qsba_datapath.sv
// ----------------------------------------------------------------------------
// qsba_datapath
// Bitmap row memory, word pointer, search hint, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module qsba_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [qsba_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] query_index
	input  wire logic [qsba_pkg::CMD_W-1:0]    s_tuser,   // [1:0] command
	input  wire qsba_pkg::ctrl_cmd_t           cmd,
	output qsba_pkg::dp_status_t               status,
	output logic [qsba_pkg::M_DATA_W-1:0]      m_tdata,   // [7:0] acquired_index,
	                                                      // [8] started_flag,
	                                                      // [9] has_room
	output logic                               m_tuser    // [0] success
);
	import qsba_pkg::*;

	// Row = {started word, used word}; a row never written reads as zero
	logic [ROW_W-1:0]      row_mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] row_vld_q;
	logic [ROW_W-1:0]      rdata_q;

	cmd_t               op_q;
	logic [INDEX_W-1:0] q_q;
	logic [WPTR_W-1:0]  wptr_q;
	logic [HINT_W-1:0]  hint_q;

	logic               res_success_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               res_started_q;

	logic               out_success_q;
	logic [INDEX_W-1:0] out_index_q;
	logic               out_started_q;
	logic               out_room_q;

	logic [WORD_BITS-1:0] used_w, start_w, qbit;
	logic [BIT_W-1:0]     free_b;
	logic [HINT_W-1:0]    slot;
	logic [WPTR_W-1:0]    hint_word;
	logic                 q_ok, hint_cap, word_full;
	logic                 wr_en;
	logic [ROW_W-1:0]     wr_row;

	assign used_w    = rdata_q[WORD_BITS-1:0];
	assign start_w   = rdata_q[ROW_W-1:WORD_BITS];
	assign qbit      = {{(WORD_BITS-1){1'b0}}, 1'b1} << q_q[BIT_W-1:0];
	assign free_b    = lowest_clear(used_w);
	assign slot      = (HINT_W'(wptr_q) << BIT_W) | HINT_W'(free_b);
	assign q_ok      = 32'(q_q) < 32'(SLOT_COUNT);
	assign hint_cap  = hint_q >= HINT_W'(SLOT_COUNT);
	assign hint_word = WPTR_W'(hint_q >> BIT_W);
	assign word_full = used_w == FULL_WORD;

	// Status toward the controller
	always_comb begin
		status.acquire    = op_q == CMD_ACQUIRE;
		status.release_op = op_q == CMD_RELEASE;
		status.skip       = (op_q == CMD_ACQUIRE) ? hint_cap : !q_ok;
		status.word_full  = word_full;
		status.ptr_last   = wptr_q == WPTR_W'(WORD_COUNT - 1);
		status.need_chk   = (HINT_W'(q_q) < hint_q) && !hint_cap && (hint_word != wptr_q);
	end

	// Row update for the executing command
	always_comb begin
		wr_en  = 1'b0;
		wr_row = rdata_q;
		case (op_q)
			CMD_ACQUIRE: begin
				wr_en  = cmd.exec && !word_full;
				wr_row = {start_w, used_w | ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_b)};
			end
			CMD_RELEASE: begin
				wr_en  = cmd.exec;
				wr_row = {start_w, used_w & ~qbit};
			end
			CMD_MARK: begin
				wr_en  = cmd.exec;
				wr_row = {start_w | qbit, used_w};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Row memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) row_mem[wptr_q] <= wr_row;
		rdata_q <= row_vld_q[wptr_q] ? row_mem[wptr_q] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wptr_q] <= 1'b1;
		end
	end

	// Latch request, steer word pointer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= cmd_t'(s_tuser);
			q_q    <= s_tdata[INDEX_W-1:0];
			wptr_q <= (cmd_t'(s_tuser) == CMD_ACQUIRE) ? hint_word
			                                            : WPTR_W'(s_tdata >> BIT_W);
		end else if (cmd.inc_ptr) begin
			wptr_q <= wptr_q + WPTR_W'(1);
		end else if (cmd.load_hw) begin
			wptr_q <= hint_word;
		end
	end

	// Search hint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
		end else if (cmd.exec && op_q == CMD_ACQUIRE && !word_full) begin
			hint_q <= slot + HINT_W'(1);
		end else if (cmd.check && word_full) begin
			hint_q <= HINT_W'(q_q);
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_success_q <= cmd_t'(s_tuser) != CMD_ACQUIRE;
			res_index_q   <= '0;
			res_started_q <= 1'b0;
		end else if (cmd.exec) begin
			if (op_q == CMD_ACQUIRE && !word_full) begin
				res_success_q <= 1'b1;
				res_index_q   <= INDEX_W'(slot);
			end
			if (op_q == CMD_CHECK) res_started_q <= |(start_w & qbit);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_success_q <= res_success_q;
			out_index_q   <= res_index_q;
			out_started_q <= res_started_q;
			out_room_q    <= !hint_cap;
		end
	end

	assign m_tuser = out_success_q;
	assign m_tdata = {{(M_DATA_W-INDEX_W-2){1'b0}}, out_room_q, out_started_q, out_index_q};

endmodule

`default_nettype wire

// File: hdl/query_slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// query_slot_bitmap_allocator
// Slot allocator over a used-bit map with a search hint and started bits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the command (acquire,
//   release, mark started, check started), s_tdata the slot index. Each
//   request yields exactly one result on the m_ stream: m_tuser is success,
//   m_tdata holds acquired_index, started_flag and has_room.
//   One request is in work at a time. s_tready is high only while idle.
//   From acceptance to m_tvalid: an acquire with the hint at capacity goes
//   through fetch straight to done; mark, check and release go through fetch
//   and execute; a release that must check the hint's word adds a check fetch
//   and a check; an acquire fetches and evaluates each of its one to four
//   scanned words in turn, since the bitmap row memory has a single read port:
//   each scanned word needs one read and one evaluate step.
//   A finished result sits in the output register; while the receiver stalls
//   the next request is still accepted and worked, and holds its result until
//   the output register frees up.
//   Reset clears the map (valid bits per row), the started bits, the hint
//   and the output valid at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module query_slot_bitmap_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [qsba_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] query_index
	input  wire logic [qsba_pkg::CMD_W-1:0]    s_tuser,   // [1:0] command
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [qsba_pkg::M_DATA_W-1:0]      m_tdata,   // [7:0] acquired_index,
	                                                      // [8] started_flag,
	                                                      // [9] has_room
	output logic                               m_tuser    // [0] success
);
	import qsba_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	// Sequencer
	qsba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (dp_status),
		.cmd      (ctrl_cmd)
	);

	// Bitmap storage and result path
	qsba_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (ctrl_cmd),
		.status  (dp_status),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`include "query_slot_bitmap_allocator_assert.svh"

	// Only one request in work at a time
	`QSBA_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "request accepted while busy")
	// Never overwrite a result that has not been taken
	`QSBA_ASSERT(a_push_free, ctrl_cmd.push |-> (!m_tvalid || m_tready), "result overwritten")
	// A taken result with no new push leaves the output empty
	`QSBA_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !ctrl_cmd.push, !m_tvalid, "result repeated")
	// A failed acquire grants slot zero
	`QSBA_ASSERT(a_fail_zero, (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0), "bad failed index")

endmodule

`default_nettype wire

// File: verif/query_slot_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_slot_bitmap_allocator_tb
// Drives acquire, release, mark started and check started requests into the
// slot allocator with random gaps and output stalls. A scoreboard tracks its
// own used map, started map and search hint and checks every result in order.
// ----------------------------------------------------------------------------

module query_slot_bitmap_allocator_tb;

	import qsba_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic               success;
		logic [INDEX_W-1:0] index;
		logic               started;
		logic               room;
	} alloc_reply_t;

	// Slot state mirror and queue of replies still to come
	class slot_alloc_board;
		logic [WORD_BITS-1:0] used_words [WORD_COUNT];
		logic [WORD_BITS-1:0] started_words [WORD_COUNT];
		int                   hint;
		alloc_reply_t         awaited_replies [$];
		int                   mismatches;
		int                   cmd_count [4];
		int                   refused;
		int                   refused_at_cap;
		int                   hint_pulled;

		function new();
			for (int w = 0; w < WORD_COUNT; w++) begin
				used_words[w] = '0;
				started_words[w] = '0;
			end
			for (int c = 0; c < 4; c++)
				cmd_count[c] = 0;
			hint = 0;
			mismatches = 0;
			refused = 0;
			refused_at_cap = 0;
			hint_pulled = 0;
		endfunction

		// Advance the mirror by one accepted request and queue its reply
		function void note_request(cmd_t cmd, logic [INDEX_W-1:0] slot);
			alloc_reply_t r;
			int b;
			int hw;
			r.success = 1'b1;
			r.index = '0;
			r.started = 1'b0;
			cmd_count[cmd]++;
			case (cmd)
				CMD_ACQUIRE: begin
					r.success = 1'b0;
					// take the lowest clear bit of the first non-full word from the hint
					for (int w = hint / WORD_BITS; w < WORD_COUNT && !r.success; w++) begin
						if (used_words[w] != FULL_WORD) begin
							b = 0;
							while (b < WORD_BITS - 1 && used_words[w][b])
								b++;
							used_words[w][b] = 1'b1;
							hint = w * WORD_BITS + b + 1;
							r.index = INDEX_W'(w * WORD_BITS + b);
							r.success = 1'b1;
						end
					end
					if (!r.success) begin
						refused++;
						if (hint >= SLOT_COUNT)
							refused_at_cap++;
					end
				end
				CMD_RELEASE: begin
					if (slot < SLOT_COUNT) begin
						used_words[slot / WORD_BITS][slot % WORD_BITS] = 1'b0;
						// pull the hint back only when its own word is full
						hw = hint / WORD_BITS;
						if (slot < hint && hw < WORD_COUNT && used_words[hw] == FULL_WORD) begin
							hint = slot;
							hint_pulled++;
						end
					end
				end
				CMD_MARK: begin
					if (slot < SLOT_COUNT)
						started_words[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
				end
				default: begin
					if (slot < SLOT_COUNT)
						r.started = started_words[slot / WORD_BITS][slot % WORD_BITS];
				end
			endcase
			r.room = (hint < SLOT_COUNT);
			awaited_replies.push_back(r);
		endfunction

		// Compare one result against the oldest queued reply
		function void check_result(logic ok, logic [INDEX_W-1:0] idx, logic st, logic room);
			alloc_reply_t r;
			if (awaited_replies.size() == 0) begin
				$error("result with no request outstanding: success %0d index %0d", ok, idx);
				mismatches++;
				return;
			end
			r = awaited_replies.pop_front();
			if (ok !== r.success) begin
				$error("success: expected %0d, actual %0d", r.success, ok);
				mismatches++;
			end
			if (idx !== r.index) begin
				$error("acquired_index: expected %0d, actual %0d", r.index, idx);
				mismatches++;
			end
			if (st !== r.started) begin
				$error("started_flag: expected %0d, actual %0d", r.started, st);
				mismatches++;
			end
			if (room !== r.room) begin
				$error("has_room: expected %0d, actual %0d", r.room, room);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return awaited_replies.size();
		endfunction

		// Prefer a slot that is currently held so releases do real work
		function logic [INDEX_W-1:0] pick_used_slot();
			logic [INDEX_W-1:0] s;
			s = INDEX_W'($urandom_range(0, SLOT_COUNT - 1));
			for (int i = 0; i < 16; i++) begin
				if (used_words[s / WORD_BITS][s % WORD_BITS])
					return s;
				s = INDEX_W'($urandom_range(0, SLOT_COUNT - 1));
			end
			return s;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [7:0] query_index
	logic [CMD_W-1:0]    s_tuser;   // [1:0] command
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // [7:0] acquired_index, [8] started_flag, [9] has_room
	logic                m_tuser;   // [0] success

	slot_alloc_board board;
	bit              quiet_tail;
	int              cycle_count;

	query_slot_bitmap_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[query_slot_bitmap_allocator] ERROR");
		$finish;
	end

	// Stall the result stream in random bursts, never in the tail
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Check each result taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9]);
	end

	// Present one request, hold until taken, then maybe drop valid for a while
	task automatic send_request(input cmd_t cmd, input logic [INDEX_W-1:0] slot);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= slot;
		do @(posedge clk); while (!s_tready);
		board.note_request(cmd, slot);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Draw one request from the given command mix
	task automatic issue_random(input int acq_pct, input int rel_pct, input int used_pct);
		int                 roll;
		cmd_t               cmd;
		logic [INDEX_W-1:0] slot;
		roll = $urandom_range(0, 99);
		slot = INDEX_W'($urandom_range(0, 255));
		if (roll < acq_pct) begin
			cmd = CMD_ACQUIRE;
		end else if (roll < acq_pct + rel_pct) begin
			cmd = CMD_RELEASE;
			if ($urandom_range(0, 99) < used_pct)
				slot = board.pick_used_slot();
		end else begin
			cmd = ($urandom_range(0, 1) != 0) ? CMD_MARK : CMD_CHECK;
		end
		send_request(cmd, slot);
	endtask

	initial begin
		board = new();
		quiet_tail = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_ACQUIRE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: started bits at both ends, first grants, release below the hint
		send_request(CMD_CHECK, 8'd0);
		send_request(CMD_MARK, 8'd0);
		send_request(CMD_CHECK, 8'd0);
		send_request(CMD_MARK, 8'd255);
		send_request(CMD_CHECK, 8'd255);
		send_request(CMD_CHECK, 8'd254);
		send_request(CMD_ACQUIRE, 8'hFF);
		send_request(CMD_ACQUIRE, 8'h00);
		send_request(CMD_ACQUIRE, 8'hAA);
		send_request(CMD_RELEASE, 8'd1);
		send_request(CMD_ACQUIRE, 8'h55);
		send_request(CMD_RELEASE, 8'd255);
		send_request(CMD_RELEASE, 8'd0);
		send_request(CMD_ACQUIRE, 8'h00);
		send_request(CMD_CHECK, 8'd128);
		send_request(CMD_MARK, 8'd128);
		send_request(CMD_CHECK, 8'd128);
		send_request(CMD_RELEASE, 8'd2);
		send_request(CMD_ACQUIRE, 8'h0F);

		// Fill the map past capacity so the hint runs out and acquires get refused
		repeat (340) issue_random(85, 7, 80);

		// Hold off until every result is back
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);

		// Drain and refill with a release-heavy mix
		repeat (200) issue_random(30, 45, 70);

		// Tail with no idling on either side
		quiet_tail = 1'b1;
		repeat (80) issue_random(40, 35, 70);

		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d acquires, %0d releases, %0d marks, %0d checks",
			board.cmd_count[CMD_ACQUIRE], board.cmd_count[CMD_RELEASE],
			board.cmd_count[CMD_MARK], board.cmd_count[CMD_CHECK]);
		$display("%0d acquires refused (%0d with hint at capacity), %0d hint pull-backs",
			board.refused, board.refused_at_cap, board.hint_pulled);
		if (board.mismatches == 0) begin
			$display("[query_slot_bitmap_allocator] OK");
		end else begin
			$display("[query_slot_bitmap_allocator] ERROR");
		end
		$finish;
	end

endmodule
